FILE: hw/rtl/pfma_pkg.sv
// package for the prime field modular alu
// holds operation codes, controller/datapath command and status types
// no dependencies
`default_nettype none

package pfma_pkg;

  // operation select codes
  localparam logic [1:0] FUNC_MUL = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_POW = 2'd2;

  localparam int OPND_BITS = 31;
  localparam int EXP_BITS  = 31;
  localparam int EXP_CNT_BITS = 5;
  localparam logic [31:0] MODULUS_RESET = 32'h7fff_ffff;

  // number of bits scanned by the shift-add multiplier
  function automatic int mul_steps(input int mb);
    mul_steps = (mb > OPND_BITS) ? mb : OPND_BITS;
  endfunction

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL_START,
    CMD_MUL_STEP,
    CMD_MUL_WB,
    CMD_SUB,
    CMD_PONE,
    CMD_ZERO,
    CMD_EXP_SHIFT,
    CMD_PUBLISH
  } cmd_op_t;

  // multiplier jobs: operand sources and write-back target
  typedef enum logic [2:0] {
    MOP_RED_A,
    MOP_RED_B,
    MOP_MUL,
    MOP_ACC,
    MOP_SQR
  } mop_t;

  typedef struct packed {
    cmd_op_t op;
    mop_t    mop;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       m_small;
    logic       exp_bit;
  } status_t;

endpackage : pfma_pkg

`default_nettype wire

FILE: hw/rtl/pfma_dpath.sv
// datapath of the prime field modular alu: modulus register, operand
// registers, shift-add modular multiplier, subtractor, result register
// depends on pfma_pkg
`default_nettype none

module pfma_dpath
  import pfma_pkg::*;
#(
  parameter int MODULUS_BITS = 31
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [MODULUS_BITS-1:0] cfg_data,
  input  wire logic [1:0]              func,
  input  wire logic [OPND_BITS-1:0]    operand_a,
  input  wire logic [OPND_BITS-1:0]    operand_b,
  input  wire cmd_t                    cmd,
  output status_t                      status,
  output logic [MODULUS_BITS-1:0]      result
);

  localparam int MB = MODULUS_BITS;
  localparam int XW = mul_steps(MODULUS_BITS);
  localparam logic [MB-1:0] MOD_RESET = MB'(MODULUS_RESET);

  logic [MB-1:0]        m;
  logic [1:0]           func_r;
  logic [OPND_BITS-1:0] opa;
  logic [OPND_BITS-1:0] opb;
  logic [EXP_BITS-1:0]  expo;
  logic [MB-1:0]        ra;
  logic [MB-1:0]        rb;
  logic [MB-1:0]        pr;
  logic [XW-1:0]        xr;
  logic [MB-1:0]        y;
  logic [MB-1:0]        acc;

  logic [MB+1:0] t;
  logic [MB+1:0] m1;
  logic [MB+1:0] m2;
  logic [MB+1:0] step_val;
  logic [MB:0]   diff;
  logic [XW-1:0] x_sel;
  logic [MB-1:0] y_sel;

  // one multiplier step: 2*acc + bit*y lies below 3m, so subtract 0, m or 2m
  always_comb begin
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    t  = {1'b0, acc, 1'b0} + (xr[XW-1] ? {2'b00, y} : '0);
    if (t >= m2) begin
      step_val = t - m2;
    end else if (t >= m1) begin
      step_val = t - m1;
    end else begin
      step_val = t;
    end
  end

  always_comb begin
    if (ra >= rb) begin
      diff = {1'b0, ra} - {1'b0, rb};
    end else begin
      diff = {1'b0, ra} + {1'b0, m} - {1'b0, rb};
    end
  end

  always_comb begin
    case (cmd.mop)
      MOP_RED_A: begin
        x_sel = XW'(opa);
        y_sel = MB'(1);
      end
      MOP_RED_B: begin
        x_sel = XW'(opb);
        y_sel = MB'(1);
      end
      MOP_MUL: begin
        x_sel = XW'(ra);
        y_sel = rb;
      end
      MOP_ACC: begin
        x_sel = XW'(pr);
        y_sel = ra;
      end
      MOP_SQR: begin
        x_sel = XW'(ra);
        y_sel = ra;
      end
      default: begin
        x_sel = '0;
        y_sel = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m <= MOD_RESET;
    end else if (cfg_we) begin
      m <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        func_r <= func;
        opa    <= operand_a;
        opb    <= operand_b;
        expo   <= operand_b;
      end
      CMD_MUL_START: begin
        xr  <= x_sel;
        y   <= y_sel;
        acc <= '0;
      end
      CMD_MUL_STEP: begin
        xr  <= {xr[XW-2:0], 1'b0};
        acc <= step_val[MB-1:0];
      end
      CMD_MUL_WB: begin
        case (cmd.mop)
          MOP_RED_A: ra <= acc;
          MOP_RED_B: rb <= acc;
          MOP_SQR:   ra <= acc;
          default:   pr <= acc;
        endcase
      end
      CMD_SUB:       pr <= diff[MB-1:0];
      CMD_PONE:      pr <= MB'(1);
      CMD_ZERO:      pr <= '0;
      CMD_EXP_SHIFT: expo <= {1'b0, expo[EXP_BITS-1:1]};
      CMD_PUBLISH:   result <= pr;
      default: ;
    endcase
  end

  assign status.func    = func_r;
  assign status.m_small = (m < MB'(2));
  assign status.exp_bit = expo[0];

endmodule : pfma_dpath

`default_nettype wire

FILE: hw/rtl/pfma_ctrl.sv
// controller of the prime field modular alu: sequences reductions,
// multiplies and exponent scan, and owns the handshakes
// depends on pfma_pkg
`default_nettype none

module pfma_ctrl
  import pfma_pkg::*;
#(
  parameter int MODULUS_BITS = 31
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam int XW = mul_steps(MODULUS_BITS);
  localparam int CW = $clog2(XW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MSTART,
    S_MSTEP,
    S_MWB,
    S_SUB,
    S_PONE,
    S_EBIT,
    S_ESHIFT,
    S_DONE
  } state_t;

  state_t                  state;
  mop_t                    mop;
  logic [CW-1:0]           cnt;
  logic [EXP_CNT_BITS-1:0] ecnt;
  logic                    out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd.mop = mop;
    case (state)
      S_IDLE:     cmd.op = in_valid ? CMD_LOAD : CMD_NONE;
      S_DISPATCH: cmd.op = (status.m_small || status.func > FUNC_POW) ? CMD_ZERO : CMD_NONE;
      S_MSTART:   cmd.op = CMD_MUL_START;
      S_MSTEP:    cmd.op = CMD_MUL_STEP;
      S_MWB:      cmd.op = CMD_MUL_WB;
      S_SUB:      cmd.op = CMD_SUB;
      S_PONE:     cmd.op = CMD_PONE;
      S_ESHIFT:   cmd.op = CMD_EXP_SHIFT;
      S_DONE:     cmd.op = out_free ? CMD_PUBLISH : CMD_NONE;
      default:    cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mop       <= MOP_RED_A;
      cnt       <= '0;
      ecnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result takes the output register as soon as it is free
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (status.m_small || status.func > FUNC_POW) begin
            state <= S_DONE;
          end else begin
            mop   <= MOP_RED_A;
            state <= S_MSTART;
          end
        end
        S_MSTART: begin
          cnt   <= '0;
          state <= S_MSTEP;
        end
        S_MSTEP: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(XW - 1)) begin
            state <= S_MWB;
          end
        end
        S_MWB: begin
          case (mop)
            MOP_RED_A: begin
              if (status.func == FUNC_POW) begin
                state <= S_PONE;
              end else begin
                mop   <= MOP_RED_B;
                state <= S_MSTART;
              end
            end
            MOP_RED_B: begin
              if (status.func == FUNC_MUL) begin
                mop   <= MOP_MUL;
                state <= S_MSTART;
              end else begin
                state <= S_SUB;
              end
            end
            MOP_ACC: begin
              mop   <= MOP_SQR;
              state <= S_MSTART;
            end
            MOP_SQR: state <= S_ESHIFT;
            default: state <= S_DONE;
          endcase
        end
        S_SUB: state <= S_DONE;
        S_PONE: begin
          ecnt  <= '0;
          state <= S_EBIT;
        end
        S_EBIT: begin
          mop   <= status.exp_bit ? MOP_ACC : MOP_SQR;
          state <= S_MSTART;
        end
        S_ESHIFT: begin
          ecnt <= ecnt + EXP_CNT_BITS'(1);
          if (ecnt == EXP_CNT_BITS'(EXP_BITS - 1)) begin
            state <= S_DONE;
          end else begin
            state <= S_EBIT;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule : pfma_ctrl

`default_nettype wire

FILE: hw/rtl/prime_field_modular_alu_core.sv
// top level of the prime field modular alu
// joins pfma_ctrl and pfma_dpath; depends on pfma_pkg
`default_nettype none

// Modular arithmetic over a prime field whose modulus (below 2^MODULUS_BITS)
// sits in a configuration register, reset to 2^31-1. Each item carries func
// (0 multiply, 1 subtract, 2 power) and two 31-bit operands; one result item
// comes back per item. Operands are first reduced modulo the modulus (for
// power only the base), then multiply gives a*b mod p, subtract gives a-b
// mod p, power gives a^b mod p by right-to-left square-and-multiply over all
// 31 exponent bits (exponent zero gives 1). A modulus of 0 or 1, or func 3,
// gives 0. Everything goes through one shift-add modular multiplier that
// scans one multiplier bit per cycle, S steps with S = 31 or MODULUS_BITS if
// larger, for each multiplier job (reduction, product or square). Multiply
// runs three jobs, subtract two reductions and then the subtraction, power
// one reduction, then a square for each exponent bit and a product for each
// set bit; a zero result runs no job. The block then returns to idle before
// it can accept the next item, and it holds a finished result for as long
// as an earlier one still waits in the output register. One item is worked
// on at a time; in_stall is high from acceptance until its result is
// written to the output register. The output register lets the next item
// be accepted while an earlier result waits to be taken.
// Write the modulus only while the block is idle.
module prime_field_modular_alu_core
  import pfma_pkg::*;
#(
  parameter int MODULUS_BITS = 31
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration
  input  wire logic                    cfg_we,
  input  wire logic [MODULUS_BITS-1:0] cfg_data,
  // input items
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              func,
  input  wire logic [OPND_BITS-1:0]    operand_a,
  input  wire logic [OPND_BITS-1:0]    operand_b,
  // result items
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [MODULUS_BITS-1:0]      result
);

  // command from sequencer to datapath, status back
  cmd_t    cmd;
  status_t status;

  pfma_ctrl #(
    .MODULUS_BITS(MODULUS_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath captures the item on the accepting edge and holds the result
  pfma_dpath #(
    .MODULUS_BITS(MODULUS_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .func      (func),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule : prime_field_modular_alu_core

`default_nettype wire

FILE: hw/rtl/pfma_checker.sv
// port-level checks for the prime field modular alu
// bound to prime_field_modular_alu_core; depends on pfma_pkg
`default_nettype none

module pfma_checker
  import pfma_pkg::*;
#(
  parameter int MODULUS_BITS = 31
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [MODULUS_BITS-1:0] result
);

  // a waiting result is neither dropped nor altered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(result))
    else $error("result changed while stalled");

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // a fresh result appears only as the block goes back to idle
  a_publish_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result published while still busy");

endmodule : pfma_checker

bind prime_field_modular_alu_core pfma_checker #(
  .MODULUS_BITS(MODULUS_BITS)
) u_pfma_checker (.*);

`default_nettype wire
